// File: hw/rtl/dtc_pkg.sv
package dtc_pkg;

   // Field widths of the triangle word and of the intermediate results.
   localparam int COORD_W = 16;
   localparam int SCALE_W = 16;
   localparam int PROD_W  = COORD_W + SCALE_W;
   localparam int RND_W   = PROD_W + 1;
   localparam int FRAC_W  = 12;
   localparam int SHIFT_W = RND_W - FRAC_W;
   localparam int EDGE_W  = COORD_W + 1;
   localparam int XPROD_W = 2 * EDGE_W;
   localparam int XCOMP_W = XPROD_W + 1;
   localparam int ROOT_W  = 32;
   localparam int SQ_W    = 2 * ROOT_W;
   localparam int AREA_W  = 63;
   localparam int SUM_W   = AREA_W + 2;

   // A triangle carries three vertices of three axes each.
   localparam int AXES  = 3;
   localparam int TRI_N = 3 * AXES;
   localparam int AX_X  = 0;
   localparam int AX_Y  = 1;
   localparam int AX_Z  = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [SCALE_W-1:0] scale_type;
   typedef logic [AREA_W-1:0]         area_type;

   localparam scale_type SCALE_ONE = 16'sd4096;
   localparam logic signed [RND_W-1:0] RND_HALF = 33'sd2048;
   localparam logic signed [SHIFT_W-1:0] COORD_MAX = 21'sd32767;
   localparam logic signed [SHIFT_W-1:0] COORD_MIN = -21'sd32768;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_SCALE_X        = 2'd0,
      CSR_SCALE_Y        = 2'd1,
      CSR_SCALE_Z        = 2'd2,
      CSR_AREA_THRESHOLD = 2'd3
   } csr_index_type;

endpackage

// File: hw/rtl/dtc_scale.sv
module dtc_scale
   import dtc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  coord_type in_coord [TRI_N],
   input  scale_type scale [AXES],
   output logic      out_valid,
   input  logic      out_ready,
   output coord_type out_coord [TRI_N]
);

   logic vld1_ff;
   logic vld2_ff;
   logic rdy1;
   logic rdy2;
   logic signed [PROD_W-1:0]  prod_in [TRI_N];
   logic signed [PROD_W-1:0]  prod_ff [TRI_N];
   logic signed [RND_W-1:0]   rnd [TRI_N];
   logic signed [SHIFT_W-1:0] rq [TRI_N];
   coord_type                 sat_in [TRI_N];
   coord_type                 sat_ff [TRI_N];

   // A stage takes a new word when it is empty or its word moves on.
   assign rdy2     = !vld2_ff || out_ready;
   assign rdy1     = !vld1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage one: each coordinate times the scale of its axis, exact Q20.12.
   always_comb begin
      for (int i = 0; i < TRI_N; i++) begin
         prod_in[i] = in_coord[i] * scale[i % AXES];
      end
   end

   // Stage two: round half up to Q16.0, then saturate to 16 bits.
   always_comb begin
      for (int i = 0; i < TRI_N; i++) begin
         rnd[i] = RND_W'(prod_ff[i]) + RND_HALF;
         rq[i]  = rnd[i][RND_W-1:FRAC_W];
         if (rq[i] > COORD_MAX) begin
            sat_in[i] = COORD_MAX[COORD_W-1:0];
         end else if (rq[i] < COORD_MIN) begin
            sat_in[i] = COORD_MIN[COORD_W-1:0];
         end else begin
            sat_in[i] = rq[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            vld1_ff <= in_valid;
         end
         if (rdy2) begin
            vld2_ff <= vld1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         prod_ff <= prod_in;
      end
      if (rdy2 && vld1_ff) begin
         sat_ff <= sat_in;
      end
   end

   assign out_valid = vld2_ff;
   assign out_coord = sat_ff;

   // A word taken at the input sits in stage one on the next cycle.
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> vld1_ff)
      else $error("accepted word missing from the multiply stage");

   // A word that leaves stage one lands in stage two.
   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      (vld1_ff && rdy2) |=> vld2_ff)
      else $error("word lost between multiply and rounding stages");

endmodule

// File: hw/rtl/dtc_cross.sv
module dtc_cross
   import dtc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  coord_type in_coord [TRI_N],
   output logic      out_valid,
   input  logic      out_ready,
   output coord_type out_coord [TRI_N],
   output logic signed [XCOMP_W-1:0] out_comp [AXES]
);

   logic vld3_ff;
   logic vld4_ff;
   logic vld5_ff;
   logic rdy3;
   logic rdy4;
   logic rdy5;
   coord_type coord3_ff [TRI_N];
   coord_type coord4_ff [TRI_N];
   coord_type coord5_ff [TRI_N];
   logic signed [EDGE_W-1:0]  edge_in [2*AXES];
   logic signed [EDGE_W-1:0]  edge_ff [2*AXES];
   logic signed [XPROD_W-1:0] prod_in [2*AXES];
   logic signed [XPROD_W-1:0] prod_ff [2*AXES];
   logic signed [XCOMP_W-1:0] comp_in [AXES];
   logic signed [XCOMP_W-1:0] comp_ff [AXES];

   assign rdy5     = !vld5_ff || out_ready;
   assign rdy4     = !vld4_ff || rdy5;
   assign rdy3     = !vld3_ff || rdy4;
   assign in_ready = rdy3;

   // Edges from the first vertex: e0 = B - A in the low half, e1 = C - A above.
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         edge_in[k]        = EDGE_W'(in_coord[AXES+k]) - EDGE_W'(in_coord[k]);
         edge_in[AXES + k] = EDGE_W'(in_coord[2*AXES+k]) - EDGE_W'(in_coord[k]);
      end
   end

   // The six partial products of e0 x e1, paired by component.
   always_comb begin
      prod_in[0] = edge_ff[AX_Y] * edge_ff[AXES+AX_Z];
      prod_in[1] = edge_ff[AX_Z] * edge_ff[AXES+AX_Y];
      prod_in[2] = edge_ff[AX_Z] * edge_ff[AXES+AX_X];
      prod_in[3] = edge_ff[AX_X] * edge_ff[AXES+AX_Z];
      prod_in[4] = edge_ff[AX_X] * edge_ff[AXES+AX_Y];
      prod_in[5] = edge_ff[AX_Y] * edge_ff[AXES+AX_X];
   end

   // Cross product components, exact.
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         comp_in[k] = XCOMP_W'(prod_ff[2*k]) - XCOMP_W'(prod_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         if (rdy3) begin
            vld3_ff <= in_valid;
         end
         if (rdy4) begin
            vld4_ff <= vld3_ff;
         end
         if (rdy5) begin
            vld5_ff <= vld4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && in_valid) begin
         edge_ff   <= edge_in;
         coord3_ff <= in_coord;
      end
      if (rdy4 && vld3_ff) begin
         prod_ff   <= prod_in;
         coord4_ff <= coord3_ff;
      end
      if (rdy5 && vld4_ff) begin
         comp_ff   <= comp_in;
         coord5_ff <= coord4_ff;
      end
   end

   assign out_valid = vld5_ff;
   assign out_coord = coord5_ff;
   assign out_comp  = comp_ff;

endmodule

// File: hw/rtl/dtc_area.sv
module dtc_area
   import dtc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  coord_type in_coord [TRI_N],
   input  logic signed [XCOMP_W-1:0] in_comp [AXES],
   input  area_type  threshold,
   output logic      out_valid,
   input  logic      out_ready,
   output coord_type out_coord [TRI_N],
   output logic      out_culled
);

   logic vld6_ff;
   logic vld7_ff;
   logic vld8_ff;
   logic vld9_ff;
   logic rdy6;
   logic rdy7;
   logic rdy8;
   logic rdy9;
   coord_type coord6_ff [TRI_N];
   coord_type coord7_ff [TRI_N];
   coord_type coord8_ff [TRI_N];
   coord_type coord9_ff [TRI_N];
   logic [XCOMP_W-1:0] abs_val [AXES];
   logic [ROOT_W-1:0]  mag_ff [AXES];
   logic [AXES-1:0]    big_in;
   logic [AXES-1:0]    big_ff;
   logic [SQ_W-1:0]    sq_full [AXES];
   logic [AREA_W-1:0]  sq_ff [AXES];
   logic [AXES-1:0]    capsq_in;
   logic [AXES-1:0]    capsq_ff;
   logic [SUM_W-1:0]   sum_full;
   area_type           sum_ff;
   logic               cap_in;
   logic               cap_ff;
   logic               culled_in;
   logic               culled_ff;

   assign rdy9     = !vld9_ff || out_ready;
   assign rdy8     = !vld8_ff || rdy9;
   assign rdy7     = !vld7_ff || rdy8;
   assign rdy6     = !vld6_ff || rdy7;
   assign in_ready = rdy6;

   // Magnitude of each component; one of 2^32 or more squares past the cap.
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         abs_val[k] = in_comp[k][XCOMP_W-1] ? XCOMP_W'(-in_comp[k]) : in_comp[k];
         big_in[k]  = |abs_val[k][XCOMP_W-1:ROOT_W];
      end
   end

   // Squares; bit 63 set also means the cap is reached.
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         sq_full[k]  = SQ_W'(mag_ff[k]) * SQ_W'(mag_ff[k]);
         capsq_in[k] = big_ff[k] | sq_full[k][SQ_W-1];
      end
   end

   // Squared length, flagged as capped once it reaches 2^63.
   always_comb begin
      sum_full = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      cap_in   = (|capsq_ff) | (|sum_full[SUM_W-1:AREA_W]);
   end

   // A capped length is always above the threshold.
   assign culled_in = !cap_ff && (sum_ff <= threshold);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
         vld9_ff <= 1'b0;
      end else begin
         if (rdy6) begin
            vld6_ff <= in_valid;
         end
         if (rdy7) begin
            vld7_ff <= vld6_ff;
         end
         if (rdy8) begin
            vld8_ff <= vld7_ff;
         end
         if (rdy9) begin
            vld9_ff <= vld8_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6 && in_valid) begin
         for (int k = 0; k < AXES; k++) begin
            mag_ff[k] <= abs_val[k][ROOT_W-1:0];
         end
         big_ff    <= big_in;
         coord6_ff <= in_coord;
      end
      if (rdy7 && vld6_ff) begin
         for (int k = 0; k < AXES; k++) begin
            sq_ff[k] <= sq_full[k][AREA_W-1:0];
         end
         capsq_ff  <= capsq_in;
         coord7_ff <= coord6_ff;
      end
      if (rdy8 && vld7_ff) begin
         sum_ff    <= sum_full[AREA_W-1:0];
         cap_ff    <= cap_in;
         coord8_ff <= coord7_ff;
      end
      if (rdy9 && vld8_ff) begin
         culled_ff <= culled_in;
         coord9_ff <= coord8_ff;
      end
   end

   assign out_valid  = vld9_ff;
   assign out_coord  = coord9_ff;
   assign out_culled = culled_ff;

   // A capped length must never produce a culled word.
   a_cap_kept: assert property (@(posedge clock) disable iff (reset)
      (vld8_ff && cap_ff && rdy9) |=> (vld9_ff && !culled_ff))
      else $error("triangle with capped area was culled");

endmodule

// File: hw/rtl/degenerate_triangle_cull.sv
// Throughput: one triangle per cycle; nine pipeline stages, each with a valid bit,
// stall together only where a stage holds a word that cannot move on.
// The last stage is the output register; a waiting response holds it and stalls each full stage behind it.
// Reset clears all valid bits; scales return to 1.0 and area_threshold to 0.
module degenerate_triangle_cull
   import dtc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_a_x,
   input  logic signed [15:0]  req_a_y,
   input  logic signed [15:0]  req_a_z,
   input  logic signed [15:0]  req_b_x,
   input  logic signed [15:0]  req_b_y,
   input  logic signed [15:0]  req_b_z,
   input  logic signed [15:0]  req_c_x,
   input  logic signed [15:0]  req_c_y,
   input  logic signed [15:0]  req_c_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_culled,
   output logic signed [15:0]  rsp_sa_x,
   output logic signed [15:0]  rsp_sa_y,
   output logic signed [15:0]  rsp_sa_z,
   output logic signed [15:0]  rsp_sb_x,
   output logic signed [15:0]  rsp_sb_y,
   output logic signed [15:0]  rsp_sb_z,
   output logic signed [15:0]  rsp_sc_x,
   output logic signed [15:0]  rsp_sc_y,
   output logic signed [15:0]  rsp_sc_z,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [62:0]         csr_wdata
);

   scale_type     scale_ff [AXES];
   area_type      threshold_ff;
   csr_index_type csr_sel;
   coord_type     req_coord [TRI_N];
   coord_type     scl_coord [TRI_N];
   coord_type     crs_coord [TRI_N];
   coord_type     rsp_coord [TRI_N];
   logic signed [XCOMP_W-1:0] crs_comp [AXES];
   logic scl_valid;
   logic scl_ready;
   logic crs_valid;
   logic crs_ready;

   assign csr_sel = csr_index_type'(csr_index);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff[AX_X] <= SCALE_ONE;
         scale_ff[AX_Y] <= SCALE_ONE;
         scale_ff[AX_Z] <= SCALE_ONE;
         threshold_ff   <= '0;
      end else if (csr_we) begin
         case (csr_sel)
            CSR_SCALE_X: begin
               scale_ff[AX_X] <= csr_wdata[SCALE_W-1:0];
            end
            CSR_SCALE_Y: begin
               scale_ff[AX_Y] <= csr_wdata[SCALE_W-1:0];
            end
            CSR_SCALE_Z: begin
               scale_ff[AX_Z] <= csr_wdata[SCALE_W-1:0];
            end
            CSR_AREA_THRESHOLD: begin
               threshold_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Request word into vertex order A, B, C with axes x, y, z.
   assign req_coord[0] = req_a_x;
   assign req_coord[1] = req_a_y;
   assign req_coord[2] = req_a_z;
   assign req_coord[3] = req_b_x;
   assign req_coord[4] = req_b_y;
   assign req_coord[5] = req_b_z;
   assign req_coord[6] = req_c_x;
   assign req_coord[7] = req_c_y;
   assign req_coord[8] = req_c_z;

   dtc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_coord  (req_coord),
      .scale     (scale_ff),
      .out_valid (scl_valid),
      .out_ready (scl_ready),
      .out_coord (scl_coord)
   );

   dtc_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scl_valid),
      .in_ready  (scl_ready),
      .in_coord  (scl_coord),
      .out_valid (crs_valid),
      .out_ready (crs_ready),
      .out_coord (crs_coord),
      .out_comp  (crs_comp)
   );

   dtc_area u_area (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (crs_valid),
      .in_ready   (crs_ready),
      .in_coord   (crs_coord),
      .in_comp    (crs_comp),
      .threshold  (threshold_ff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_coord  (rsp_coord),
      .out_culled (rsp_culled)
   );

   assign rsp_sa_x = rsp_coord[0];
   assign rsp_sa_y = rsp_coord[1];
   assign rsp_sa_z = rsp_coord[2];
   assign rsp_sb_x = rsp_coord[3];
   assign rsp_sb_y = rsp_coord[4];
   assign rsp_sb_z = rsp_coord[5];
   assign rsp_sc_x = rsp_coord[6];
   assign rsp_sc_y = rsp_coord[7];
   assign rsp_sc_z = rsp_coord[8];

   // The pipeline refuses a word only when the response side is stalled.
   a_ready_on_drain: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("pipeline refused a word while the response side drains");

endmodule
